// ===== rtl/mbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbaf_pkg: shared types and constants for the Modbus ASCII request framer
// Holds the command format between the front and back ends, status codes,
// frame characters and the nibble-to-hex conversion.
// ----------------------------------------------------------------------------
package mbaf_pkg;

  // Status codes carried with every result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SLAVE = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_BAD_CODE  = 2'd3
  } status_t;

  // Function codes the framer knows.
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  // Highest slave id a request may address.
  localparam logic [7:0] MAX_SLAVE = 8'd247;

  // Frame characters.
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Largest number of bytes one command carries (write multiple header).
  localparam int CMD_BYTES = 9;
  localparam int NBYTES_W  = $clog2(CMD_BYTES + 1);
  localparam int BIDX_W    = $clog2(CMD_BYTES);

  // Command queue depth between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified request as the back end sees it.
  typedef struct packed {
    logic                             err;        // emit a single error result
    status_t                          status;     // error kind when err is set
    logic                             colon;      // open a new frame with ':'
    logic                             frame_end;  // close with LRC, CR, LF
    logic [NBYTES_W-1:0]              nbytes;     // bytes to send as hex pairs
    logic [CMD_BYTES-1:0][7:0]        bytes;      // byte 0 goes out first
  } cmd_t;

  // Uppercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h41 + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

// ===== rtl/mbaf_front.sv =====
// ----------------------------------------------------------------------------
// mbaf_front: request classifier
// Decides whether a request opens a frame, continues a write multiple or is
// rejected, and turns it into a command of bytes for the back end.
// ----------------------------------------------------------------------------
module mbaf_front #(
  parameter int MAX_WRITE_REGS = 123
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       slave_addr,
  input  logic [7:0]       function_code,
  input  logic [15:0]      start_address,
  input  logic [7:0]       item_count,
  input  logic [15:0]      data_word,
  output mbaf_pkg::cmd_t   cmd
);
  import mbaf_pkg::*;

  logic [6:0] words_remaining;
  logic [6:0] words_remaining_next;
  logic       count_bad;

  assign count_bad = (item_count == 8'd0) || (item_count > 8'(MAX_WRITE_REGS));

  // Classify the request and lay out its bytes in send order.
  always_comb begin
    cmd                  = '0;
    cmd.status           = ST_OK;
    words_remaining_next = words_remaining;
    if (words_remaining != 7'd0) begin
      // Continuation: one data word of a pending write multiple.
      cmd.nbytes           = NBYTES_W'(2);
      cmd.bytes[0]         = data_word[15:8];
      cmd.bytes[1]         = data_word[7:0];
      cmd.frame_end        = (words_remaining == 7'd1);
      words_remaining_next = words_remaining - 7'd1;
    end else if (slave_addr > MAX_SLAVE) begin
      cmd.err    = 1'b1;
      cmd.status = ST_BAD_SLAVE;
    end else begin
      cmd.bytes[0] = slave_addr;
      cmd.bytes[1] = function_code;
      cmd.bytes[2] = start_address[15:8];
      cmd.bytes[3] = start_address[7:0];
      case (function_code)
        FC_READ_HOLDING: begin
          cmd.colon     = 1'b1;
          cmd.frame_end = 1'b1;
          cmd.nbytes    = NBYTES_W'(6);
          cmd.bytes[4]  = 8'd0;
          cmd.bytes[5]  = item_count;
        end
        FC_WRITE_COIL, FC_WRITE_REG: begin
          cmd.colon     = 1'b1;
          cmd.frame_end = 1'b1;
          cmd.nbytes    = NBYTES_W'(6);
          cmd.bytes[4]  = data_word[15:8];
          cmd.bytes[5]  = data_word[7:0];
        end
        FC_WRITE_MULTI: begin
          if (count_bad) begin
            cmd.err    = 1'b1;
            cmd.status = ST_BAD_COUNT;
          end else begin
            cmd.colon            = 1'b1;
            cmd.frame_end        = (item_count == 8'd1);
            cmd.nbytes           = NBYTES_W'(9);
            cmd.bytes[4]         = 8'd0;
            cmd.bytes[5]         = item_count;
            cmd.bytes[6]         = {item_count[6:0], 1'b0};
            cmd.bytes[7]         = data_word[15:8];
            cmd.bytes[8]         = data_word[7:0];
            words_remaining_next = item_count[6:0] - 7'd1;
          end
        end
        default: begin
          cmd.err    = 1'b1;
          cmd.status = ST_BAD_CODE;
        end
      endcase
    end
  end

  // Data words still owed to an open write multiple.
  always_ff @(posedge clk) begin
    if (rst) begin
      words_remaining <= 7'd0;
    end else if (accept) begin
      words_remaining <= words_remaining_next;
    end
  end

  // A valid write multiple header leaves exactly count - 1 words pending.
  a_words_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && words_remaining == 7'd0 && cmd.colon && function_code == FC_WRITE_MULTI
    |=> words_remaining == 7'($past(item_count) - 8'd1))
    else $error("words_remaining not loaded from item_count");

  // A continuation never opens a frame or reports an error.
  a_cont_plain: assert property (@(posedge clk) disable iff (rst)
    words_remaining != 7'd0 |-> !cmd.colon && !cmd.err)
    else $error("continuation classified as header");

  // The frame closes together with the last pending word.
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    accept && words_remaining == 7'd1 |=> words_remaining == 7'd0)
    else $error("write multiple did not return to header state");

endmodule

// ===== rtl/mbaf_queue.sv =====
// ----------------------------------------------------------------------------
// mbaf_queue: command queue
// A short first-in first-out queue of commands that lets the classifier and
// the character serializer stall independently.
// ----------------------------------------------------------------------------
module mbaf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbaf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mbaf_pkg::cmd_t head_cmd
);
  import mbaf_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from empty command queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== rtl/mbaf_back.sv =====
// ----------------------------------------------------------------------------
// mbaf_back: character serializer
// Takes queued commands and sends one character per cycle unless m_tready
// stalls: the colon, each byte as two hex digits, the LRC, CR and LF, or a
// single error result. Keeps the running LRC sum and the output register.
// ----------------------------------------------------------------------------
module mbaf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mbaf_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);
  import mbaf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ERR    = 8'b0000_0010,
    S_COLON  = 8'b0000_0100,
    S_DATA   = 8'b0000_1000,
    S_LRC_HI = 8'b0001_0000,
    S_LRC_LO = 8'b0010_0000,
    S_CR     = 8'b0100_0000,
    S_LF     = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  cmd_t              cur, cur_next;
  logic [BIDX_W-1:0] idx, idx_next;
  logic              nib, nib_next;
  logic [7:0]        sum, sum_next;
  logic              advance;
  logic              emit;
  logic              finish;
  logic [7:0]        ch;
  status_t           st;
  logic              last;
  logic [7:0]        cur_byte;
  logic [7:0]        lrc;

  assign advance  = !m_tvalid || m_tready;
  assign cur_byte = cur.bytes[idx];
  assign lrc      = ~sum + 8'd1;

  // Pick the character for this step and where to go next.
  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    nib_next   = nib;
    sum_next   = sum;
    emit       = 1'b0;
    finish     = 1'b0;
    ch         = CHAR_NONE;
    st         = ST_OK;
    last       = 1'b0;
    q_pop      = 1'b0;
    if (advance) begin
      case (state)
        S_IDLE: begin
        end
        S_ERR: begin
          emit   = 1'b1;
          st     = cur.status;
          last   = 1'b1;
          finish = 1'b1;
        end
        S_COLON: begin
          emit       = 1'b1;
          ch         = CHAR_COLON;
          sum_next   = 8'd0;
          state_next = S_DATA;
        end
        S_DATA: begin
          emit     = 1'b1;
          ch       = hex_digit(nib ? cur_byte[3:0] : cur_byte[7:4]);
          nib_next = ~nib;
          if (nib) begin
            sum_next = sum + cur_byte;
            if (NBYTES_W'(idx) == cur.nbytes - NBYTES_W'(1)) begin
              if (cur.frame_end) begin
                state_next = S_LRC_HI;
              end else begin
                finish = 1'b1;
              end
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end
        S_LRC_HI: begin
          emit       = 1'b1;
          ch         = hex_digit(lrc[7:4]);
          state_next = S_LRC_LO;
        end
        S_LRC_LO: begin
          emit       = 1'b1;
          ch         = hex_digit(lrc[3:0]);
          state_next = S_CR;
        end
        S_CR: begin
          emit       = 1'b1;
          ch         = CHAR_CR;
          state_next = S_LF;
        end
        S_LF: begin
          emit     = 1'b1;
          ch       = CHAR_LF;
          last     = 1'b1;
          sum_next = 8'd0;
          finish   = 1'b1;
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
    // Load the next command when idle or right after the current one ends.
    if ((state == S_IDLE || finish) && q_valid) begin
      q_pop    = 1'b1;
      cur_next = q_head;
      idx_next = '0;
      nib_next = 1'b0;
      if (q_head.err) begin
        state_next = S_ERR;
      end else if (q_head.colon) begin
        state_next = S_COLON;
      end else begin
        state_next = S_DATA;
      end
    end else if (finish) begin
      state_next = S_IDLE;
    end
  end

  // Sequencer state and running LRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= 8'd0;
      idx   <= '0;
      nib   <= 1'b0;
    end else begin
      state <= state_next;
      sum   <= sum_next;
      idx   <= idx_next;
      nib   <= nib_next;
    end
  end

  // Current command payload.
  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= ch;
      m_tuser <= st;
      m_tlast <= last;
    end
  end

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == CHAR_LF || m_tuser != ST_OK)
    else $error("tlast on a character other than LF");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == CHAR_NONE)
    else $error("malformed error result");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DATA |-> NBYTES_W'(idx) < cur.nbytes)
    else $error("byte index beyond command length");

  // An idle sequencer may still load the next command during a stall.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && state != S_IDLE |=> $stable(state) && $stable(sum))
    else $error("serializer moved while output stalled");

endmodule

// ===== rtl/modbus_ascii_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_ascii_request_framer: Modbus ASCII master request framer
// Turns header and data-word requests into ':'-framed uppercase hex
// characters closed by the LRC, CR and LF, or into one error result.
//
//   Channel  Dir  Handshake                Payload
//   s_*      in   s_tvalid / s_tready      s_tdata: request fields
//   m_*      out  m_tvalid / m_tready      m_tdata: char, m_tuser: status,
//                                          m_tlast: end of frame or error
//
// A request is taken whenever the two-entry command queue has room, so
// requests flow back to back while earlier frames are still being sent.
// The serializer sends one character per cycle unless m_tready stalls it.
// A read or single write makes 17 characters, a write multiple header 19
// or 23, a data word 4 or 8 and an error 1.
// Reset (rst, synchronous) clears the queue, the sequencer and the pending
// word count. A stall on m_tready holds the output register and, once the
// queue fills, drops s_tready.
// ----------------------------------------------------------------------------
module modbus_ascii_request_framer #(
  parameter int MAX_WRITE_REGS = 123
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // slave_addr, function_code, start_address,
                                 // item_count, data_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ascii_char
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast    // last_char
);
  import mbaf_pkg::*;

  logic accept;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t front_cmd;
  cmd_t q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  mbaf_front #(
    .MAX_WRITE_REGS (MAX_WRITE_REGS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .slave_addr    (s_tdata[7:0]),
    .function_code (s_tdata[15:8]),
    .start_address (s_tdata[31:16]),
    .item_count    (s_tdata[39:32]),
    .data_word     (s_tdata[55:40]),
    .cmd           (front_cmd)
  );

  mbaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  mbaf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sim/tb_modbus_ascii_request_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_ascii_request_framer: self-checking bench for the request framer
// Sends directed and random header and data-word requests over the slave
// stream and predicts every frame character, status and end-of-frame flag.
// A scoreboard compares each character taken from the master stream with
// the oldest prediction. Both streams idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_modbus_ascii_request_framer;
  import mbaf_pkg::*;

  localparam int MAX_WRITE_REGS = 123;
  localparam int RANDOM_REQUESTS = 470;

  // One predicted character as it leaves the master stream.
  typedef struct packed {
    logic [7:0] ch;
    status_t    st;
    logic       last;
  } frame_char_t;

  // Predicts the character stream of each request and checks the output.
  class modbus_frame_scoreboard;
    logic [7:0]  lrc_sum;
    logic [6:0]  words_left;
    frame_char_t expected_chars[$];
    int          errors;

    function new();
      lrc_sum    = 8'd0;
      words_left = 7'd0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      // ASCII '0' is 8'h30 and 'A' is 8'h41.
      if (nib < 4'd10) begin
        return 8'h30 + {4'd0, nib};
      end
      return 8'h41 + {4'd0, nib} - 8'd10;
    endfunction

    function void push_char(logic [7:0] ch, status_t st, logic last);
      frame_char_t c;
      c.ch   = ch;
      c.st   = st;
      c.last = last;
      expected_chars.push_back(c);
    endfunction

    function void push_byte(logic [7:0] b);
      push_char(hex_char(b[7:4]), ST_OK, 1'b0);
      push_char(hex_char(b[3:0]), ST_OK, 1'b0);
      lrc_sum = lrc_sum + b;
    endfunction

    function void push_word(logic [15:0] w);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
    endfunction

    function void open_frame(logic [7:0] slave, logic [7:0] fc, logic [15:0] addr);
      lrc_sum = 8'd0;
      push_char(CHAR_COLON, ST_OK, 1'b0);
      push_byte(slave);
      push_byte(fc);
      push_word(addr);
    endfunction

    // The LRC is the two's complement of the byte sum since the colon.
    function void close_frame();
      logic [7:0] lrc;
      lrc = ~lrc_sum + 8'd1;
      push_char(hex_char(lrc[7:4]), ST_OK, 1'b0);
      push_char(hex_char(lrc[3:0]), ST_OK, 1'b0);
      push_char(CHAR_CR, ST_OK, 1'b0);
      push_char(CHAR_LF, ST_OK, 1'b1);
      lrc_sum = 8'd0;
    endfunction

    // Notes one accepted request and queues the characters it causes.
    function void note_request(logic [55:0] req);
      logic [7:0]  slave;
      logic [7:0]  fc;
      logic [15:0] addr;
      logic [7:0]  count;
      logic [15:0] data;
      slave = req[7:0];
      fc    = req[15:8];
      addr  = req[31:16];
      count = req[39:32];
      data  = req[55:40];

      // A pending write multiple takes every request as its next data word.
      if (words_left != 7'd0) begin
        push_word(data);
        words_left = words_left - 7'd1;
        if (words_left == 7'd0) begin
          close_frame();
        end
        return;
      end

      if (slave > MAX_SLAVE) begin
        push_char(CHAR_NONE, ST_BAD_SLAVE, 1'b1);
        return;
      end

      case (fc)
        FC_READ_HOLDING: begin
          open_frame(slave, fc, addr);
          push_word({8'd0, count});
          close_frame();
        end
        FC_WRITE_COIL, FC_WRITE_REG: begin
          open_frame(slave, fc, addr);
          push_word(data);
          close_frame();
        end
        FC_WRITE_MULTI: begin
          if (count < 8'd1 || count > MAX_WRITE_REGS) begin
            push_char(CHAR_NONE, ST_BAD_COUNT, 1'b1);
          end else begin
            open_frame(slave, fc, addr);
            push_word({8'd0, count});
            push_byte({count[6:0], 1'b0});
            push_word(data);
            words_left = count[6:0] - 7'd1;
            if (words_left == 7'd0) begin
              close_frame();
            end
          end
        end
        default: begin
          push_char(CHAR_NONE, ST_BAD_CODE, 1'b1);
        end
      endcase
    endfunction

    // Checks one character taken from the master stream.
    function void check_char(logic [7:0] ch, logic [1:0] st, logic last);
      frame_char_t exp_c;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual %h/%0d/%0b",
                 $time, ch, st, last);
        return;
      end
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        errors++;
        $display("%0t: character mismatch: expected %h, actual %h", $time, exp_c.ch, ch);
      end
      if (st !== exp_c.st) begin
        errors++;
        $display("%0t: tuser mismatch: expected %0d, actual %0d", $time, exp_c.st, st);
      end
      if (last !== exp_c.last) begin
        errors++;
        $display("%0t: tlast mismatch: expected %0b, actual %0b", $time, exp_c.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = 56'd0;  // slave_addr, function_code, start_address,
                                 // item_count, data_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // ascii_char
  logic [1:0]  m_tuser;          // status
  logic        m_tlast;          // last_char

  modbus_frame_scoreboard sb = new();
  bit quiet = 1'b0;  // no idling on either side while set
  int n_sent = 0;

  modbus_ascii_request_framer #(
    .MAX_WRITE_REGS(MAX_WRITE_REGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [55:0] pack_request(logic [7:0] slave, logic [7:0] fc,
                                               logic [15:0] addr, logic [7:0] count,
                                               logic [15:0] data);
    return {data, count, addr, fc, slave};
  endfunction

  // Offers one request, with an occasional idle burst first, and waits for it.
  task automatic send_request(input logic [55:0] req);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req);
    n_sent++;
  endtask

  // A write multiple header followed by its data words; the other fields of
  // the data-word requests are random and must be ignored.
  task automatic send_write_multi(input logic [7:0] slave, input logic [15:0] addr,
                                  input logic [7:0] count);
    logic [55:0] word;
    send_request(pack_request(slave, FC_WRITE_MULTI, addr, count, 16'($urandom())));
    for (int i = 1; i < count; i++) begin
      word = 56'({$urandom(), $urandom()});
      send_request(word);
    end
  endtask

  // Holds the sender off until every predicted character has come out.
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver: random stall bursts on m_tready.
  initial begin
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_char(m_tdata, m_tuser, m_tlast);
    end
  end

  // Stimulus.
  initial begin
    int          pick;
    int          target;
    logic [7:0]  fc;
    logic [7:0]  count;
    bit          big_done;
    big_done = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every function code and every error case.
    send_request(pack_request(8'd0, FC_READ_HOLDING, 16'h0000, 8'd0, 16'hFFFF));
    send_request(pack_request(MAX_SLAVE, FC_READ_HOLDING, 16'hFFFF, 8'd255, 16'h0000));
    send_request(pack_request(8'd1, FC_WRITE_COIL, 16'h00AC, 8'd0, 16'hFF00));
    send_request(pack_request(8'h11, FC_WRITE_REG, 16'h0001, 8'd255, 16'h0003));
    send_request(pack_request(8'd0, FC_WRITE_REG, 16'h0000, 8'd0, 16'hFFFF));
    send_write_multi(8'd10, 16'h1234, 8'd1);
    send_write_multi(MAX_SLAVE, 16'hFFFF, 8'd2);
    send_write_multi(8'd0, 16'h0000, 8'd3);
    send_request(pack_request(8'd248, FC_READ_HOLDING, 16'h0000, 8'd1, 16'h0000));
    send_request(pack_request(8'd255, FC_WRITE_REG, 16'hFFFF, 8'd1, 16'hFFFF));
    send_request(pack_request(MAX_SLAVE, 8'd0, 16'h0000, 8'd1, 16'h0000));
    send_request(pack_request(8'd1, 8'd4, 16'h0100, 8'd1, 16'h0000));
    send_request(pack_request(8'd2, 8'd255, 16'hFFFF, 8'd255, 16'hFFFF));
    send_request(pack_request(8'd3, FC_WRITE_MULTI, 16'h0000, 8'd0, 16'h0000));
    send_request(pack_request(8'd3, FC_WRITE_MULTI, 16'h0000, 8'd124, 16'h0000));
    send_request(pack_request(8'd3, FC_WRITE_MULTI, 16'h0000, 8'd255, 16'h0000));
    // Slave check wins over the function code and count checks.
    send_request(pack_request(8'd250, 8'd7, 16'h0000, 8'd1, 16'h0000));
    send_request(pack_request(8'd251, FC_WRITE_MULTI, 16'h0000, 8'd0, 16'h0000));
    drain_frames();

    // Random: mostly well-formed frames with random content, some errors.
    target = n_sent + RANDOM_REQUESTS;
    while (n_sent < target) begin
      quiet = (target - n_sent < 60) || (n_sent % 200 >= 150 && n_sent % 200 < 180);
      if (n_sent > target / 2 && n_sent < target / 2 + 5) begin
        drain_frames();
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_request(pack_request(8'($urandom_range(0, 247)), FC_READ_HOLDING,
                                  16'($urandom()), 8'($urandom()), 16'($urandom())));
      end else if (pick < 32) begin
        send_request(pack_request(8'($urandom_range(0, 247)), FC_WRITE_COIL,
                                  16'($urandom()), 8'($urandom()), 16'($urandom())));
      end else if (pick < 45) begin
        send_request(pack_request(8'($urandom_range(0, 247)), FC_WRITE_REG,
                                  16'($urandom()), 8'($urandom()), 16'($urandom())));
      end else if (pick < 83) begin
        if (!big_done && n_sent > target / 3) begin
          count = 8'(MAX_WRITE_REGS);
          big_done = 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          count = 8'($urandom_range(7, MAX_WRITE_REGS / 4));
        end else begin
          count = 8'($urandom_range(1, 6));
        end
        send_write_multi(8'($urandom_range(0, 247)), 16'($urandom()), count);
      end else if (pick < 89) begin
        send_request(pack_request(8'($urandom_range(248, 255)), 8'($urandom()),
                                  16'($urandom()), 8'($urandom()), 16'($urandom())));
      end else if (pick < 95) begin
        do fc = 8'($urandom());
        while (fc == FC_READ_HOLDING || fc == FC_WRITE_COIL ||
               fc == FC_WRITE_REG || fc == FC_WRITE_MULTI);
        send_request(pack_request(8'($urandom_range(0, 247)), fc,
                                  16'($urandom()), 8'($urandom()), 16'($urandom())));
      end else begin
        count = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(124, 255));
        send_request(pack_request(8'($urandom_range(0, 247)), FC_WRITE_MULTI,
                                  16'($urandom()), count, 16'($urandom())));
      end
    end

    // Close out any write multiple left open so every frame completes.
    while (sb.words_left != 7'd0) begin
      send_request(56'({$urandom(), $urandom()}));
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
